[design/arp_chk_pkg.sv]
// ----------------------------------------------------------------------------
// ARP checker package
// Word types, field constants and verdict codes shared by the checker files.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_chk_pkg;

  localparam int unsigned CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [15:0] HWTYPE_ETHER     = 16'd1;
  localparam logic [15:0] HWTYPE_IEEE802   = 16'd6;
  localparam logic [15:0] PROTO_IPV4       = 16'h0800;
  localparam logic [15:0] OP_REQUEST       = 16'd1;
  localparam logic [15:0] OP_REPLY         = 16'd2;
  localparam logic [15:0] OP_RARP_REQUEST  = 16'd3;
  localparam logic [15:0] OP_RARP_REPLY    = 16'd4;
  localparam logic [15:0] OP_INARP_REQUEST = 16'd8;
  localparam logic [15:0] OP_INARP_REPLY   = 16'd9;
  localparam logic [7:0]  ETHER_HLN        = 8'd6;
  localparam logic [7:0]  IPV4_PLN         = 8'd4;

  typedef enum logic [3:0] {
    VERDICT_REQUEST    = 4'd0,
    VERDICT_REPLY      = 4'd1,
    VERDICT_TRUNCATED  = 4'd2,
    VERDICT_BAD_HLEN   = 4'd3,
    VERDICT_UNKNOWN_HW = 4'd4,
    VERDICT_BAD_PLEN   = 4'd5,
    VERDICT_UNKNOWN_PR = 4'd6,
    VERDICT_SHA_DIFF   = 4'd7,
    VERDICT_UNIMPL_OP  = 4'd8,
    VERDICT_INVALID_OP = 4'd9
  } verdict_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [47:0] frame_src_mac;
    logic [47:0] frame_dst_mac;
  } in_word_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [47:0] link_src_mac;
    logic [47:0] link_dst_mac;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] op_code;
  } out_word_t;

  // Packet state after the current byte has been folded in.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [63:0]      header;
    logic [47:0]      sha;
    logic [31:0]      spa;
    logic [47:0]      tha;
    logic [31:0]      tpa;
    logic [47:0]      src_mac;
    logic [47:0]      dst_mac;
  } cap_t;

endpackage

`default_nettype wire

[design/arp_chk_if.sv]
// ----------------------------------------------------------------------------
// ARP checker channels
// Valid/ready channels for payload bytes in and verdict words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface arp_chk_in_if;
  logic                 valid;
  logic                 ready;
  arp_chk_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arp_chk_out_if;
  logic                  valid;
  logic                  ready;
  arp_chk_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/arp_chk_capture.sv]
// ----------------------------------------------------------------------------
// ARP checker field capture
// Byte counter, header and address capture at length-dependent offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_chk_capture (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire arp_chk_pkg::in_word_t word_i,
  output arp_chk_pkg::cap_t          cap_o
);
  import arp_chk_pkg::*;

  logic [CNT_W-1:0] count_q;
  logic [63:0]      header_q;
  logic [47:0]      sha_q, tha_q, src_q, dst_q;
  logic [31:0]      spa_q, tpa_q;

  logic [CNT_W-1:0] idx, cnt_inc;
  logic             first, hdr_phase;
  logic [CNT_W-1:0] hln_w, pln_w;
  logic [CNT_W-1:0] spa_start, tha_start, tpa_start;
  logic [CNT_W-1:0] k_sha, k_spa, k_tha, k_tpa;
  logic             hit_sha, hit_spa, hit_tha, hit_tpa;
  cap_t             cap_d;

  assign idx       = count_q;
  assign first     = (idx == '0);
  assign hdr_phase = (idx[CNT_W-1:3] == '0);
  assign cnt_inc   = (idx == CNT_MAX) ? idx : idx + {{(CNT_W-1){1'b0}}, 1'b1};

  // Lengths come from the stored header; only used once the header is done.
  assign hln_w     = {{(CNT_W-8){1'b0}}, header_q[31:24]};
  assign pln_w     = {{(CNT_W-8){1'b0}}, header_q[23:16]};
  assign spa_start = CNT_W'(8) + hln_w;
  assign tha_start = spa_start + pln_w;
  assign tpa_start = tha_start + hln_w;

  assign k_sha = idx - CNT_W'(8);
  assign k_spa = idx - spa_start;
  assign k_tha = idx - tha_start;
  assign k_tpa = idx - tpa_start;

  assign hit_sha = !hdr_phase && (k_sha < hln_w) && (k_sha < CNT_W'(6));
  assign hit_spa = !hdr_phase && (idx >= spa_start) && (k_spa < pln_w) &&
                   (k_spa < CNT_W'(4));
  assign hit_tha = !hdr_phase && (idx >= tha_start) && (k_tha < hln_w) &&
                   (k_tha < CNT_W'(6));
  assign hit_tpa = !hdr_phase && (idx >= tpa_start) && (k_tpa < pln_w) &&
                   (k_tpa < CNT_W'(4));

  always_comb begin
    cap_d.count   = cnt_inc;
    cap_d.header  = first ? '0 : header_q;
    cap_d.sha     = first ? '0 : sha_q;
    cap_d.spa     = first ? '0 : spa_q;
    cap_d.tha     = first ? '0 : tha_q;
    cap_d.tpa     = first ? '0 : tpa_q;
    cap_d.src_mac = first ? word_i.frame_src_mac : src_q;
    cap_d.dst_mac = first ? word_i.frame_dst_mac : dst_q;
    for (int j = 0; j < 8; j++) begin
      if (hdr_phase && (idx[2:0] == 3'(j))) begin
        cap_d.header[63-8*j -: 8] = cap_d.header[63-8*j -: 8] | word_i.data_byte;
      end
    end
    for (int j = 0; j < 6; j++) begin
      if (hit_sha && (k_sha[2:0] == 3'(j))) begin
        cap_d.sha[47-8*j -: 8] = cap_d.sha[47-8*j -: 8] | word_i.data_byte;
      end
      if (hit_tha && (k_tha[2:0] == 3'(j))) begin
        cap_d.tha[47-8*j -: 8] = cap_d.tha[47-8*j -: 8] | word_i.data_byte;
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (hit_spa && (k_spa[1:0] == 2'(j))) begin
        cap_d.spa[31-8*j -: 8] = cap_d.spa[31-8*j -: 8] | word_i.data_byte;
      end
      if (hit_tpa && (k_tpa[1:0] == 2'(j))) begin
        cap_d.tpa[31-8*j -: 8] = cap_d.tpa[31-8*j -: 8] | word_i.data_byte;
      end
    end
  end

  assign cap_o = cap_d;

  // Restart the count after the last byte of a packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= word_i.last_byte ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      header_q <= cap_d.header;
      sha_q    <= cap_d.sha;
      spa_q    <= cap_d.spa;
      tha_q    <= cap_d.tha;
      tpa_q    <= cap_d.tpa;
      src_q    <= cap_d.src_mac;
      dst_q    <= cap_d.dst_mac;
    end
  end

endmodule

`default_nettype wire

[design/arp_chk_verdict.sv]
// ----------------------------------------------------------------------------
// ARP checker verdict
// Ordered packet checks and result word assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_chk_verdict (
  input  wire arp_chk_pkg::cap_t      cap_i,
  output arp_chk_pkg::out_word_t      res_o
);
  import arp_chk_pkg::*;

  logic [15:0]      hrd, pro, op;
  logic [7:0]       hln, pln;
  logic [CNT_W-1:0] need;
  logic             trunc, mac_ok, ip_ok;
  verdict_e         verdict;

  assign hrd = cap_i.header[63:48];
  assign pro = cap_i.header[47:32];
  assign hln = cap_i.header[31:24];
  assign pln = cap_i.header[23:16];
  assign op  = cap_i.header[15:0];

  assign need  = CNT_W'(8) + {2'b00, hln, 1'b0} + {2'b00, pln, 1'b0};
  assign trunc = (cap_i.count < CNT_W'(8)) || (cap_i.count < need);
  assign mac_ok = !trunc && (hln >= ETHER_HLN);
  assign ip_ok  = !trunc && (pln >= IPV4_PLN);

  always_comb begin
    if (trunc) begin
      verdict = VERDICT_TRUNCATED;
    end else if (hrd != HWTYPE_ETHER && hrd != HWTYPE_IEEE802) begin
      verdict = VERDICT_UNKNOWN_HW;
    end else if (hln != ETHER_HLN) begin
      verdict = VERDICT_BAD_HLEN;
    end else if (pro != PROTO_IPV4) begin
      verdict = VERDICT_UNKNOWN_PR;
    end else if (pln != IPV4_PLN) begin
      verdict = VERDICT_BAD_PLEN;
    end else if (cap_i.sha != cap_i.src_mac) begin
      verdict = VERDICT_SHA_DIFF;
    end else begin
      unique case (op) inside
        OP_REQUEST: verdict = VERDICT_REQUEST;
        OP_REPLY:   verdict = VERDICT_REPLY;
        OP_RARP_REQUEST, OP_RARP_REPLY, OP_INARP_REQUEST, OP_INARP_REPLY:
          verdict = VERDICT_UNIMPL_OP;
        default:    verdict = VERDICT_INVALID_OP;
      endcase
    end
  end

  always_comb begin
    res_o.verdict      = verdict;
    res_o.sender_mac   = mac_ok ? cap_i.sha : '0;
    res_o.target_mac   = mac_ok ? cap_i.tha : '0;
    res_o.sender_ip    = ip_ok ? cap_i.spa : '0;
    res_o.target_ip    = ip_ok ? cap_i.tpa : '0;
    res_o.link_src_mac = cap_i.src_mac;
    res_o.link_dst_mac = cap_i.dst_mac;
    res_o.hw_type      = hrd;
    res_o.proto_type   = pro;
    res_o.hw_len       = hln;
    res_o.proto_len    = pln;
    res_o.op_code      = op;
  end

endmodule

`default_nettype wire

[design/arp_packet_checker_top.sv]
// ----------------------------------------------------------------------------
// ARP packet checker
// Byte-wide ARP payload parser giving one verdict word per packet.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one payload byte per word, a last-byte flag and the frame's
//         source and destination MACs, which are sampled with the first byte.
//   out_o carries one verdict word per packet: the verdict code, the captured
//         sender and target addresses, the link MACs and the header fields.
// Throughput: one byte per cycle, sustained while no last byte waits on a stalled output.
// Path: an accepted byte waits in the input register; when it moves on it is
//   folded into the packet state, and for a last byte the verdict word is
//   loaded into the output register at the same edge.
// Stall: a stalled output holds its word. Bytes that do not end a packet keep
//   flowing while the receiver stalls; a last byte waits in the input register
//   until the output word is taken, and ready drops behind it.
// Reset: clears the byte count and both valid flags; the first byte after
//   reset starts a new packet.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_packet_checker_top (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  arp_chk_in_if.sink    in_i,
  arp_chk_out_if.source out_o
);
  import arp_chk_pkg::*;

  logic      s1_valid_q;
  in_word_t  s1_q;
  logic      out_valid_q;
  out_word_t out_q;

  logic      out_space, s1_fire, in_fire;
  cap_t      cap;
  out_word_t res;

  // A byte without the last flag never needs output space.
  assign out_space = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && (!s1_q.last_byte || out_space);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire   = in_i.valid && in_i.ready;

  // Hold the byte until its packet state update can go ahead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.data;
    end
  end

  arp_chk_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .word_i (s1_q),
    .cap_o  (cap)
  );

  arp_chk_verdict u_verdict (
    .cap_i (cap),
    .res_o (res)
  );

  // Load a verdict on the last byte; drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.last_byte) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A held byte must not be lost or altered while it waits.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_q))
    else $error("held input byte lost or changed");

  // A new verdict appears only after a last byte went through.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_q.last_byte))
    else $error("verdict without a last byte");

  // A last byte never overwrites a verdict that still waits.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_q.last_byte |-> !out_valid_q || out_o.ready)
    else $error("verdict overwritten while stalled");

  // Truncated packets carry no addresses.
  a_trunc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.verdict == VERDICT_TRUNCATED |->
      out_q.sender_mac == '0 && out_q.target_mac == '0 &&
      out_q.sender_ip == '0 && out_q.target_ip == '0)
    else $error("truncated verdict with address data");

endmodule

`default_nettype wire

[dv/arp_packet_checker_top_tb.sv]
// ----------------------------------------------------------------------------
// ARP packet checker testbench
// Streams ARP payloads byte by byte into the checker, predicts each packet's
// verdict word from a behavioral copy of the parser, and compares every field
// of every verdict word. Covers a table of directed packets, a back-pressure
// burst, and random well-formed and malformed packets with idle cycles on both
// channels.
// ----------------------------------------------------------------------------

module arp_packet_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arp_chk_pkg::*;

  localparam int          NUM_DIR       = 25;
  localparam int          QUIET_LIMIT   = 3000;  // cycles without any accepted word
  localparam int          HOLD_CYCLES   = 400;   // receiver hold-off for the pressure burst
  localparam int          DRAIN_CYCLES  = 20;
  localparam int          MAX_REPORTS   = 10;
  localparam int          HDR_BYTES     = 8;
  localparam logic [15:0] ETHERTYPE_V6  = 16'h86DD;
  localparam logic [15:0] HRD_NONE      = 16'h0000;
  localparam logic [15:0] FIELD_ONES    = 16'hFFFF;

  // How the sender hardware address bytes relate to the frame source MAC.
  typedef enum logic [1:0] {
    SHA_RANDOM,   // random content
    SHA_EQUAL,    // up to six leading bytes copy the frame source MAC
    SHA_FLIPPED   // as SHA_EQUAL with one bit inverted
  } sha_mode_e;

  // One packet to send: header fields, total length (0 = exactly the header and
  // address regions), sender address mode, and a verdict typed in where it is obvious.
  typedef struct {
    logic [15:0] hrd;
    logic [15:0] pro;
    logic [7:0]  hln;
    logic [7:0]  pln;
    logic [15:0] op;
    int          tot;
    sha_mode_e   sha;
    bit          fixed;
    verdict_e    code;
  } pkt_row_t;

  typedef struct {
    bit       fixed;
    verdict_e code;
  } fixed_verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  arp_chk_in_if  in_if ();
  arp_chk_out_if out_if ();

  arp_packet_checker_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shared controls written by the stimulus process only.
  bit no_idle  = 1'b0;
  int hold_seq = 0;

  // Predicted parser state.
  int          pkt_len  = 0;
  logic [63:0] hdr_q    = '0;
  logic [47:0] sha_q    = '0;
  logic [47:0] spa_q    = '0;
  logic [47:0] tha_q    = '0;
  logic [47:0] tpa_q    = '0;
  logic [47:0] src_hold = '0;
  logic [47:0] dst_hold = '0;

  out_word_t      pending_verdicts [$];
  fixed_verdict_t fixed_verdict_q  [$];

  int errors        = 0;
  int bytes_sent    = 0;
  int bytes_taken   = 0;
  int packets_sent  = 0;
  int verdicts_seen = 0;
  int held_packets  = 0;
  int verdict_hits [10];

  // Directed packets. The header-only rows and the rows whose checks fail on
  // a single field carry their verdict; the odd-length rows go to the predictor.
  pkt_row_t dir_rows [NUM_DIR] = '{
    // one byte right after reset: truncated, only hrd high byte arrives
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 1,
      SHA_EQUAL,   1'b1, VERDICT_TRUNCATED},
    // header one byte short
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 7,
      SHA_EQUAL,   1'b1, VERDICT_TRUNCATED},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_REQUEST},
    '{HWTYPE_IEEE802, PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REPLY,   0,
      SHA_EQUAL,   1'b1, VERDICT_REPLY},
    // last target protocol byte missing
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 27,
      SHA_EQUAL,   1'b1, VERDICT_TRUNCATED},
    '{HWTYPE_ETHER,   PROTO_IPV4,   8'd5,      IPV4_PLN, OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_BAD_HLEN},
    '{FIELD_ONES,     PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_UNKNOWN_HW},
    '{HRD_NONE,       PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_UNKNOWN_HW},
    '{HWTYPE_ETHER,   ETHERTYPE_V6, ETHER_HLN, IPV4_PLN, OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_UNKNOWN_PR},
    '{HWTYPE_IEEE802, PROTO_IPV4,   ETHER_HLN, 8'd16,    OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_BAD_PLEN},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 0,
      SHA_FLIPPED, 1'b1, VERDICT_SHA_DIFF},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_RARP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_UNIMPL_OP},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_RARP_REPLY, 0,
      SHA_EQUAL,   1'b1, VERDICT_UNIMPL_OP},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_INARP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_UNIMPL_OP},
    '{HWTYPE_IEEE802, PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_INARP_REPLY, 0,
      SHA_EQUAL,   1'b1, VERDICT_UNIMPL_OP},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, 16'h0000, 0,
      SHA_EQUAL,   1'b1, VERDICT_INVALID_OP},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, FIELD_ONES, 0,
      SHA_EQUAL,   1'b1, VERDICT_INVALID_OP},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, 16'h0005, 0,
      SHA_EQUAL,   1'b1, VERDICT_INVALID_OP},
    // zero-length address regions: header only, nothing captured
    '{HWTYPE_ETHER,   PROTO_IPV4,   8'd0,      8'd0,     OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_BAD_HLEN},
    // widest regions: 8 + 2*255 + 2*255 bytes
    '{HWTYPE_ETHER,   PROTO_IPV4,   8'd255,    8'd255,   OP_REQUEST, 0,
      SHA_EQUAL,   1'b1, VERDICT_BAD_HLEN},
    // trailing bytes past every region are ignored
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REQUEST, 40,
      SHA_EQUAL,   1'b1, VERDICT_REQUEST},
    // long enough to saturate the byte counter
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, IPV4_PLN, OP_REPLY, 2100,
      SHA_EQUAL,   1'b1, VERDICT_REPLY},
    // oversized and undersized address lengths: captures clip to 6 and 4 bytes
    '{HWTYPE_IEEE802, PROTO_IPV4,   8'd7,      8'd5,     OP_REQUEST, 0,
      SHA_RANDOM,  1'b0, VERDICT_REQUEST},
    '{HWTYPE_ETHER,   PROTO_IPV4,   ETHER_HLN, 8'd3,     OP_REQUEST, 0,
      SHA_EQUAL,   1'b0, VERDICT_REQUEST},
    '{16'h0002,       16'h0000,     8'd2,      8'd1,     FIELD_ONES, 0,
      SHA_RANDOM,  1'b0, VERDICT_REQUEST}
  };

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(16'hFFFF)), $urandom()};
  endfunction

  // Drop byte b into an address register of nbytes bytes when the byte index
  // falls inside the region [start, start+len); bytes past nbytes are dropped.
  function automatic logic [47:0] place_addr_byte(input logic [47:0] cur, input int nbytes,
                                                  input int idx, input int start,
                                                  input int len, input logic [7:0] b);
    int k;
    k = idx - start;
    if (idx >= start && k < len && k < nbytes)
      cur[(nbytes-1-k)*8 +: 8] = cur[(nbytes-1-k)*8 +: 8] | b;
    return cur;
  endfunction

  // Fold one accepted byte into the predicted packet state; on the last byte
  // build the verdict word and start over.
  task automatic fold_arp_byte(input in_word_t w, output bit done, output out_word_t res);
    int          idx;
    int          hl;
    int          pl;
    logic [15:0] hrd;
    logic [15:0] pro;
    logic [15:0] op;
    verdict_e    v;
    logic [47:0] smac;
    logic [47:0] tmac;
    logic [31:0] sip;
    logic [31:0] tip;
    done = 1'b0;
    res  = '0;
    idx  = pkt_len;
    if (idx == 0) begin
      hdr_q    = '0;
      sha_q    = '0;
      spa_q    = '0;
      tha_q    = '0;
      tpa_q    = '0;
      src_hold = w.frame_src_mac;
      dst_hold = w.frame_dst_mac;
    end
    if (idx < HDR_BYTES) begin
      hdr_q[63-8*idx -: 8] = w.data_byte;
    end else begin
      hl    = int'(hdr_q[31:24]);
      pl    = int'(hdr_q[23:16]);
      sha_q = place_addr_byte(sha_q, 6, idx, HDR_BYTES, hl, w.data_byte);
      spa_q = place_addr_byte(spa_q, 4, idx, HDR_BYTES + hl, pl, w.data_byte);
      tha_q = place_addr_byte(tha_q, 6, idx, HDR_BYTES + hl + pl, hl, w.data_byte);
      tpa_q = place_addr_byte(tpa_q, 4, idx, HDR_BYTES + 2*hl + pl, pl, w.data_byte);
    end
    pkt_len = (idx + 1 > int'(CNT_MAX)) ? int'(CNT_MAX) : idx + 1;
    if (w.last_byte) begin
      hrd  = hdr_q[63:48];
      pro  = hdr_q[47:32];
      hl   = int'(hdr_q[31:24]);
      pl   = int'(hdr_q[23:16]);
      op   = hdr_q[15:0];
      smac = (hl >= 6) ? sha_q : '0;
      tmac = (hl >= 6) ? tha_q : '0;
      sip  = (pl >= 4) ? spa_q[31:0] : '0;
      tip  = (pl >= 4) ? tpa_q[31:0] : '0;
      if (pkt_len < HDR_BYTES || pkt_len < HDR_BYTES + 2*hl + 2*pl) begin
        v    = VERDICT_TRUNCATED;
        smac = '0;
        tmac = '0;
        sip  = '0;
        tip  = '0;
      end else if (hrd == HWTYPE_ETHER || hrd == HWTYPE_IEEE802) begin
        if (hl != int'(ETHER_HLN))      v = VERDICT_BAD_HLEN;
        else if (pro != PROTO_IPV4)     v = VERDICT_UNKNOWN_PR;
        else if (pl != int'(IPV4_PLN))  v = VERDICT_BAD_PLEN;
        else if (sha_q != src_hold)     v = VERDICT_SHA_DIFF;
        else if (op == OP_REQUEST)      v = VERDICT_REQUEST;
        else if (op == OP_REPLY)        v = VERDICT_REPLY;
        else if (op == OP_RARP_REQUEST || op == OP_RARP_REPLY ||
                 op == OP_INARP_REQUEST || op == OP_INARP_REPLY)
          v = VERDICT_UNIMPL_OP;
        else
          v = VERDICT_INVALID_OP;
      end else begin
        v = VERDICT_UNKNOWN_HW;
      end
      res.verdict      = v;
      res.sender_mac   = smac;
      res.sender_ip    = sip;
      res.target_mac   = tmac;
      res.target_ip    = tip;
      res.link_src_mac = src_hold;
      res.link_dst_mac = dst_hold;
      res.hw_type      = hrd;
      res.proto_type   = pro;
      res.hw_len       = hdr_q[31:24];
      res.proto_len    = hdr_q[23:16];
      res.op_code      = op;
      pkt_len          = 0;
      done             = 1'b1;
    end
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%t: verdict word %0d: %s", $time, verdicts_seen, msg);
  endtask

  task automatic cmp_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (got !== want)
      note_error($sformatf("%s expected %0h, got %0h", fname, want, got));
  endtask

  // Present one word and hold it until it is taken. Idle first at random,
  // unless the no-idle stretch is on.
  task automatic send_word(input in_word_t w);
    if (!no_idle) begin
      while ($urandom_range(99) < 20) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  // Build one packet from a row and stream it. Only the first byte carries
  // the packet's link MACs; later bytes carry noise there, which must be ignored.
  task automatic send_packet(input pkt_row_t p);
    logic [63:0]    hdr;
    logic [47:0]    src;
    logic [47:0]    dst;
    int             n;
    int             flip_k;
    int             flip_b;
    in_word_t       w;
    fixed_verdict_t f;
    hdr    = {p.hrd, p.pro, p.hln, p.pln, p.op};
    src    = rand48();
    dst    = rand48();
    n      = (p.tot == 0) ? HDR_BYTES + 2*int'(p.hln) + 2*int'(p.pln) : p.tot;
    flip_k = int'($urandom_range(5));
    flip_b = int'($urandom_range(7));
    f.fixed = p.fixed;
    f.code  = p.code;
    fixed_verdict_q.push_back(f);
    for (int i = 0; i < n; i++) begin
      w.data_byte = 8'($urandom_range(255));
      if (i < HDR_BYTES) begin
        w.data_byte = hdr[63-8*i -: 8];
      end else if (i - HDR_BYTES < 6 && i - HDR_BYTES < int'(p.hln) && p.sha != SHA_RANDOM) begin
        w.data_byte = src[47-8*(i-HDR_BYTES) -: 8];
        if (p.sha == SHA_FLIPPED && i - HDR_BYTES == flip_k)
          w.data_byte[flip_b] = ~w.data_byte[flip_b];
      end
      w.last_byte     = (i == n - 1);
      w.frame_src_mac = (i == 0) ? src : rand48();
      w.frame_dst_mac = (i == 0) ? dst : rand48();
      send_word(w);
    end
    packets_sent++;
  endtask

  // Receiver: take verdict words with random stalls, hold off for a long
  // stretch whenever the stimulus asks, and never stall in the no-idle stretch.
  initial begin : receiver
    int hold_left;
    int seen_seq;
    hold_left    = 0;
    seen_seq     = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (seen_seq != hold_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Scoreboard: predict on every accepted byte, check every accepted verdict
  // word against the oldest prediction.
  always @(posedge clk_i) begin : scoreboard
    bit             done;
    out_word_t      want;
    fixed_verdict_t f;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        bytes_taken++;
        fold_arp_byte(in_if.data, done, want);
        if (done) begin
          f = fixed_verdict_q.pop_front();
          if (f.fixed)
            want.verdict = f.code;
          pending_verdicts.push_back(want);
        end
      end
      if (out_if.valid && out_if.ready) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          note_error("verdict word with no packet pending");
        end else begin
          want = pending_verdicts.pop_front();
          verdict_hits[int'(want.verdict)]++;
          cmp_field("verdict",      64'(want.verdict),      64'(out_if.data.verdict));
          cmp_field("sender_mac",   64'(want.sender_mac),   64'(out_if.data.sender_mac));
          cmp_field("sender_ip",    64'(want.sender_ip),    64'(out_if.data.sender_ip));
          cmp_field("target_mac",   64'(want.target_mac),   64'(out_if.data.target_mac));
          cmp_field("target_ip",    64'(want.target_ip),    64'(out_if.data.target_ip));
          cmp_field("link_src_mac", 64'(want.link_src_mac), 64'(out_if.data.link_src_mac));
          cmp_field("link_dst_mac", 64'(want.link_dst_mac), 64'(out_if.data.link_dst_mac));
          cmp_field("hw_type",      64'(want.hw_type),      64'(out_if.data.hw_type));
          cmp_field("proto_type",   64'(want.proto_type),   64'(out_if.data.proto_type));
          cmp_field("hw_len",       64'(want.hw_len),       64'(out_if.data.hw_len));
          cmp_field("proto_len",    64'(want.proto_len),    64'(out_if.data.proto_len));
          cmp_field("op_code",      64'(want.op_code),      64'(out_if.data.op_code));
        end
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%t: no word accepted for %0d cycles, %0d verdict words outstanding",
             $time, QUIET_LIMIT, pending_verdicts.size());
    $display("arp_packet_checker_top_tb: FAIL");
    $finish;
  end

  // Stimulus: directed table, back-pressure burst, then random packets.
  initial begin : stimulus
    pkt_row_t row;
    int       nat;
    int       codes;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    for (int r = 0; r < NUM_DIR; r++)
      send_packet(dir_rows[r]);

    // Hold the receiver off and keep offering short packets: the output word
    // and the next last byte back up, and the input must stall behind them.
    hold_seq++;
    for (int r = 0; r < 40; r++) begin
      row.hrd   = 16'($urandom_range(16'hFFFF));
      row.pro   = 16'($urandom_range(16'hFFFF));
      row.hln   = 8'($urandom_range(255));
      row.pln   = 8'($urandom_range(255));
      row.op    = 16'($urandom_range(16'hFFFF));
      row.tot   = int'($urandom_range(1, 3));
      row.sha   = SHA_RANDOM;
      row.fixed = 1'b0;
      row.code  = VERDICT_TRUNCATED;
      send_packet(row);
      held_packets++;
    end

    // Random packets: mostly well-formed with random content, the rest noise.
    // A stretch in the middle runs with no idling on either side.
    for (int r = 0; bytes_sent < 500 + 2200 || r < 60; r++) begin
      no_idle   = (r >= 20 && r < 32);
      row.fixed = 1'b0;
      row.code  = VERDICT_REQUEST;
      if ($urandom_range(99) < 70) begin
        row.hrd = $urandom_range(1) ? HWTYPE_ETHER : HWTYPE_IEEE802;
        row.pro = PROTO_IPV4;
        row.hln = ETHER_HLN;
        row.pln = IPV4_PLN;
        case ($urandom_range(7))
          0, 1:    row.op = OP_REQUEST;
          2, 3:    row.op = OP_REPLY;
          4:       row.op = OP_RARP_REQUEST;
          5:       row.op = OP_RARP_REPLY;
          6:       row.op = $urandom_range(1) ? OP_INARP_REQUEST : OP_INARP_REPLY;
          default: row.op = 16'($urandom_range(16'hFFFF));
        endcase
        row.tot = ($urandom_range(3) == 0) ? 28 + int'($urandom_range(12)) : 0;
        row.sha = ($urandom_range(9) == 0) ? SHA_FLIPPED : SHA_EQUAL;
      end else begin
        row.hrd = $urandom_range(1) ? 16'($urandom_range(16'hFFFF)) :
                  ($urandom_range(1) ? HWTYPE_ETHER : HWTYPE_IEEE802);
        row.pro = $urandom_range(1) ? 16'($urandom_range(16'hFFFF)) : PROTO_IPV4;
        row.hln = 8'(($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(10));
        row.pln = 8'(($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(8));
        row.op  = 16'($urandom_range(16'hFFFF));
        row.sha = $urandom_range(1) ? SHA_EQUAL : SHA_RANDOM;
        nat     = HDR_BYTES + 2*int'(row.hln) + 2*int'(row.pln);
        case ($urandom_range(3))
          0:       row.tot = 0;
          1:       row.tot = nat - int'($urandom_range(1, 3));
          2:       row.tot = int'($urandom_range(1, 12));
          default: row.tot = nat + int'($urandom_range(1, 5));
        endcase
      end
      send_packet(row);
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;

    // Wait for the last byte to be folded in, then drain.
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    codes = 0;
    foreach (verdict_hits[i])
      if (verdict_hits[i] != 0) codes++;
    $display("arp checker run: %0d bytes in %0d packets (%0d behind a stalled receiver)",
             bytes_taken, packets_sent, held_packets);
    $display("arp checker run: %0d verdict words checked, %0d of 10 verdict codes hit, %0d errors",
             verdicts_seen, codes, errors);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("arp_packet_checker_top_tb: PASS");
    end else begin
      $display("arp_packet_checker_top_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/arp_chk_pkg.sv
design/arp_chk_if.sv
design/arp_chk_capture.sv
design/arp_chk_verdict.sv
design/arp_packet_checker_top.sv
dv/arp_packet_checker_top_tb.sv
